/* rtl/core/min_heap_timer_queue_assert.svh */
// Assertion macros for the timer queue. Both sample on clk and are off while rst_n is low.
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MHTQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MHTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/mhtq_pkg.sv */
`timescale 1ns / 1ps

package mhtq_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int ID_BITS_DEF   = 8;
  localparam int TIME_BITS_DEF = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_ADJUST = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_TICK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_FIRED       = 3'd1,
    ST_NOT_FOUND   = 3'd2,
    ST_FULL        = 3'd3,
    ST_NOTHING_DUE = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_LOADX,
    S_UP,
    S_UPRD,
    S_UPWR,
    S_DOWN,
    S_DNL,
    S_DNR,
    S_DNCMP,
    S_DNWR,
    S_PUTX,
    S_RESP,
    S_TICK
  } state_t;

  // Ring control: rot_up brings the next higher slot to the port cell,
  // rot_dn the next lower one; wr_en loads the port cell.
  typedef struct packed {
    logic rot_up;
    logic rot_dn;
    logic wr_en;
  } ring_ctl_t;

endpackage

/* rtl/core/min_heap_timer_queue.sv */
`timescale 1ns / 1ps
// Timer queue: binary min-heap kept in a ring of CAPACITY cells, one slot per cell.
// The controller sees only the port cell; the ring moves the port by one slot at a time.
// Latency grows with the entry count n, and a search checks one slot at a time.
// One item at a time; the next item is taken while a result waits in the output register.
// rst_n (synchronous, active low) empties the queue at once; slot contents are not cleared.

module min_heap_timer_queue import mhtq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // timer_id, expire_time, now_time from bit 0 up, zero padded
  input  logic [((ID_BITS+2*TIME_BITS+7)/8)*8-1:0]  in_tdata,
  // cmd
  input  logic [1:0]                                in_tuser,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // fired_id, zero padded
  output logic [((ID_BITS+7)/8)*8-1:0]              out_tdata,
  // status
  output logic [2:0]                                out_tuser,
  output logic                                      out_tlast
);

  localparam int OUT_DW = ((ID_BITS + 7) / 8) * 8;

  ring_ctl_t            ring_ctl;
  logic [ID_BITS-1:0]   wr_id;
  logic [TIME_BITS-1:0] wr_exp;
  logic [ID_BITS-1:0]   cell_id  [CAPACITY];
  logic [TIME_BITS-1:0] cell_exp [CAPACITY];
  status_t              out_status;
  logic [ID_BITS-1:0]   out_id;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_ring
    localparam int UP = (k + 1) % CAPACITY;
    localparam int DN = (k + CAPACITY - 1) % CAPACITY;
    ring_ctl_t cctl;

    // Only cell 0 is the port cell.
    assign cctl = '{rot_up: ring_ctl.rot_up, rot_dn: ring_ctl.rot_dn,
                    wr_en: (k == 0) && ring_ctl.wr_en};

    mhtq_cell #(
      .ID_BITS  (ID_BITS),
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk     (clk),
      .ctl     (cctl),
      .up_id   (cell_id[UP]),
      .up_exp  (cell_exp[UP]),
      .dn_id   (cell_id[DN]),
      .dn_exp  (cell_exp[DN]),
      .wr_id   (wr_id),
      .wr_exp  (wr_exp),
      .slot_id (cell_id[k]),
      .slot_exp(cell_exp[k])
    );
  end

  mhtq_ctrl #(
    .CAPACITY (CAPACITY),
    .ID_BITS  (ID_BITS),
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_cmd    (in_tuser),
    .in_id     (in_tdata[ID_BITS-1:0]),
    .in_exp    (in_tdata[ID_BITS+TIME_BITS-1:ID_BITS]),
    .in_now    (in_tdata[ID_BITS+2*TIME_BITS-1:ID_BITS+TIME_BITS]),
    .port_id   (cell_id[0]),
    .port_exp  (cell_exp[0]),
    .ring_ctl  (ring_ctl),
    .wr_id     (wr_id),
    .wr_exp    (wr_exp),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_status(out_status),
    .out_id    (out_id),
    .out_last  (out_tlast)
  );

  assign out_tdata = OUT_DW'(out_id);
  assign out_tuser = out_status;

endmodule

/* rtl/core/mhtq_cell.sv */
`timescale 1ns / 1ps

module mhtq_cell import mhtq_pkg::*; #(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  ring_ctl_t            ctl,
  input  logic [ID_BITS-1:0]   up_id,
  input  logic [TIME_BITS-1:0] up_exp,
  input  logic [ID_BITS-1:0]   dn_id,
  input  logic [TIME_BITS-1:0] dn_exp,
  input  logic [ID_BITS-1:0]   wr_id,
  input  logic [TIME_BITS-1:0] wr_exp,
  output logic [ID_BITS-1:0]   slot_id,
  output logic [TIME_BITS-1:0] slot_exp
);

  logic [ID_BITS-1:0]   slot_id_r;
  logic [TIME_BITS-1:0] slot_exp_r;

  always_ff @(posedge clk) begin
    priority if (ctl.wr_en) begin
      slot_id_r  <= wr_id;
      slot_exp_r <= wr_exp;
    end else if (ctl.rot_up) begin
      slot_id_r  <= up_id;
      slot_exp_r <= up_exp;
    end else if (ctl.rot_dn) begin
      slot_id_r  <= dn_id;
      slot_exp_r <= dn_exp;
    end else begin
      slot_id_r  <= slot_id_r;
      slot_exp_r <= slot_exp_r;
    end
  end

  assign slot_id  = slot_id_r;
  assign slot_exp = slot_exp_r;

endmodule

/* rtl/core/mhtq_ctrl.sv */
`timescale 1ns / 1ps

module mhtq_ctrl import mhtq_pkg::*; #(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [1:0]           in_cmd,
  input  logic [ID_BITS-1:0]   in_id,
  input  logic [TIME_BITS-1:0] in_exp,
  input  logic [TIME_BITS-1:0] in_now,
  input  logic [ID_BITS-1:0]   port_id,
  input  logic [TIME_BITS-1:0] port_exp,
  output ring_ctl_t            ring_ctl,
  output logic [ID_BITS-1:0]   wr_id,
  output logic [TIME_BITS-1:0] wr_exp,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output status_t              out_status,
  output logic [ID_BITS-1:0]   out_id,
  output logic                 out_last
);

`include "min_heap_timer_queue_assert.svh"

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = PW + 2;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        off_r, off_nxt;
  logic [CW-1:0]        scan_r, scan_nxt;
  logic [PW-1:0]        hole_r, hole_nxt;
  logic                 first_r, first_nxt;
  logic [ID_BITS-1:0]   x_id_r, x_id_nxt;
  logic [TIME_BITS-1:0] x_exp_r, x_exp_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [ID_BITS-1:0]   c_id_r, c_id_nxt;
  logic [TIME_BITS-1:0] c_exp_r, c_exp_nxt;
  logic [PW-1:0]        c_idx_r, c_idx_nxt;
  status_t              stat_r, stat_nxt;
  logic                 pend_r, pend_nxt;
  logic [ID_BITS-1:0]   pend_id_r, pend_id_nxt;

  logic                 out_tvalid_r;
  status_t              out_status_r;
  logic [ID_BITS-1:0]   out_id_r;
  logic                 out_last_r;

  logic [KW-1:0]        left_k, right_k, count_k;
  logic [PW-1:0]        parent_idx;
  logic [PW-1:0]        seek;
  logic                 seeking;
  logic                 at;
  logic                 out_free;
  logic                 scan_done;
  logic                 due;
  logic                 emit;
  status_t              e_status;
  logic [ID_BITS-1:0]   e_id;
  logic                 e_last;

  assign left_k     = KW'({hole_r, 1'b1});
  assign right_k    = left_k + 1'b1;
  assign count_k    = KW'(count_r);
  assign parent_idx = PW'((hole_r - 1'b1) >> 1);
  assign scan_done  = (scan_r == count_r);
  assign due        = (count_r != '0) && (port_exp <= now_r);
  assign out_free   = !out_tvalid_r || out_tready;

  // Slot the port cell has to reach in the current state.
  always_comb begin
    seek    = '0;
    seeking = 1'b0;
    unique case (state_r)
      S_FIND: begin
        seek    = scan_r[PW-1:0];
        seeking = !scan_done;
      end
      S_LOADX: begin
        seek    = count_r[PW-1:0];
        seeking = 1'b1;
      end
      S_UPRD: begin
        seek    = parent_idx;
        seeking = 1'b1;
      end
      S_UPWR, S_DNWR, S_PUTX: begin
        seek    = hole_r;
        seeking = 1'b1;
      end
      S_DNL: begin
        seek    = left_k[PW-1:0];
        seeking = 1'b1;
      end
      S_DNR: begin
        seek    = right_k[PW-1:0];
        seeking = 1'b1;
      end
      S_TICK: begin
        seek    = '0;
        seeking = 1'b1;
      end
      default: begin
        seek    = '0;
        seeking = 1'b0;
      end
    endcase
  end

  assign at = (off_r == seek);

  // Next state and datapath registers.
  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    count_nxt   = count_r;
    scan_nxt    = scan_r;
    hole_nxt    = hole_r;
    first_nxt   = first_r;
    x_id_nxt    = x_id_r;
    x_exp_nxt   = x_exp_r;
    now_nxt     = now_r;
    c_id_nxt    = c_id_r;
    c_exp_nxt   = c_exp_r;
    c_idx_nxt   = c_idx_r;
    stat_nxt    = stat_r;
    pend_nxt    = pend_r;
    pend_id_nxt = pend_id_r;
    off_nxt     = off_r;

    if (ring_ctl.rot_up) begin
      off_nxt = off_r + 1'b1;
    end else if (ring_ctl.rot_dn) begin
      off_nxt = off_r - 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = cmd_t'(in_cmd);
          x_id_nxt  = in_id;
          x_exp_nxt = in_exp;
          now_nxt   = in_now;
          scan_nxt  = '0;
          pend_nxt  = 1'b0;
          first_nxt = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_ADD: begin
              if (count_r == CW'(CAPACITY)) begin
                stat_nxt  = ST_FULL;
                state_nxt = S_RESP;
              end else begin
                hole_nxt  = count_r[PW-1:0];
                count_nxt = count_r + 1'b1;
                state_nxt = S_UP;
              end
            end
            CMD_ADJUST, CMD_DELETE: begin
              state_nxt = S_FIND;
            end
            CMD_TICK: begin
              state_nxt = S_TICK;
            end
          endcase
        end
      end
      S_FIND: begin
        if (scan_done) begin
          stat_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else if (at) begin
          if (port_id == x_id_r) begin
            hole_nxt = scan_r[PW-1:0];
            if (cmd_r == CMD_DELETE) begin
              count_nxt = count_r - 1'b1;
              // Drop the final slot outright; otherwise refill from it.
              if (scan_r == count_r - 1'b1) begin
                stat_nxt  = ST_OK;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_LOADX;
              end
            end else begin
              state_nxt = S_UP;
            end
          end else begin
            scan_nxt = scan_r + 1'b1;
          end
        end
      end
      S_LOADX: begin
        if (at) begin
          x_id_nxt  = port_id;
          x_exp_nxt = port_exp;
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (hole_r == '0) begin
          first_nxt = 1'b0;
          state_nxt = first_r ? S_DOWN : S_PUTX;
        end else begin
          state_nxt = S_UPRD;
        end
      end
      S_UPRD: begin
        if (at) begin
          if (x_exp_r < port_exp) begin
            c_id_nxt  = port_id;
            c_exp_nxt = port_exp;
            state_nxt = S_UPWR;
          end else begin
            first_nxt = 1'b0;
            state_nxt = first_r ? S_DOWN : S_PUTX;
          end
        end
      end
      S_UPWR: begin
        if (at) begin
          hole_nxt  = parent_idx;
          first_nxt = 1'b0;
          state_nxt = S_UP;
        end
      end
      S_DOWN: begin
        state_nxt = (left_k >= count_k) ? S_PUTX : S_DNL;
      end
      S_DNL: begin
        if (at) begin
          c_id_nxt  = port_id;
          c_exp_nxt = port_exp;
          c_idx_nxt = left_k[PW-1:0];
          state_nxt = (right_k < count_k) ? S_DNR : S_DNCMP;
        end
      end
      S_DNR: begin
        if (at) begin
          // Left child wins ties.
          if (c_exp_r > port_exp) begin
            c_id_nxt  = port_id;
            c_exp_nxt = port_exp;
            c_idx_nxt = right_k[PW-1:0];
          end
          state_nxt = S_DNCMP;
        end
      end
      S_DNCMP: begin
        state_nxt = (c_exp_r >= x_exp_r) ? S_PUTX : S_DNWR;
      end
      S_DNWR: begin
        if (at) begin
          hole_nxt  = c_idx_r;
          state_nxt = S_DOWN;
        end
      end
      S_PUTX: begin
        if (at) begin
          if (cmd_r == CMD_TICK) begin
            state_nxt = S_TICK;
          end else begin
            stat_nxt  = ST_OK;
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_TICK: begin
        if (at && out_free) begin
          if (due) begin
            pend_nxt    = 1'b1;
            pend_id_nxt = port_id;
            count_nxt   = count_r - 1'b1;
            if (count_r != CW'(1)) begin
              hole_nxt  = '0;
              first_nxt = 1'b1;
              state_nxt = S_LOADX;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Handshake, ring control and result emission.
  always_comb begin
    in_tready       = (state_r == S_IDLE);
    ring_ctl.rot_up = seeking && (off_r < seek);
    ring_ctl.rot_dn = seeking && (off_r > seek);
    ring_ctl.wr_en  = 1'b0;
    wr_id           = c_id_r;
    wr_exp          = c_exp_r;
    emit            = 1'b0;
    e_status        = ST_OK;
    e_id            = '0;
    e_last          = 1'b1;
    unique case (state_r)
      S_UPWR, S_DNWR: begin
        ring_ctl.wr_en = at;
      end
      S_PUTX: begin
        ring_ctl.wr_en = at;
        wr_id          = x_id_r;
        wr_exp         = x_exp_r;
      end
      S_RESP: begin
        emit     = out_free;
        e_status = stat_r;
      end
      S_TICK: begin
        if (at && out_free) begin
          // Hold the previous fired id until it is known whether it is the final one.
          if (due) begin
            emit     = pend_r;
            e_status = ST_FIRED;
            e_id     = pend_id_r;
            e_last   = 1'b0;
          end else begin
            emit     = 1'b1;
            e_status = pend_r ? ST_FIRED : ST_NOTHING_DUE;
            e_id     = pend_r ? pend_id_r : '0;
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      off_r        <= '0;
      pend_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      off_r   <= off_nxt;
      pend_r  <= pend_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    scan_r    <= scan_nxt;
    hole_r    <= hole_nxt;
    first_r   <= first_nxt;
    x_id_r    <= x_id_nxt;
    x_exp_r   <= x_exp_nxt;
    now_r     <= now_nxt;
    c_id_r    <= c_id_nxt;
    c_exp_r   <= c_exp_nxt;
    c_idx_r   <= c_idx_nxt;
    stat_r    <= stat_nxt;
    pend_id_r <= pend_id_nxt;
    if (emit) begin
      out_status_r <= e_status;
      out_id_r     <= e_id;
      out_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_last   = out_last_r;

  `MHTQ_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(CAPACITY), "entry count above capacity")
  `MHTQ_ASSERT_NEXT(a_rot_up, ring_ctl.rot_up, off_r == PW'($past(off_r) + 1'b1), "port offset lost on rotate up")
  `MHTQ_ASSERT_NEXT(a_rot_dn, ring_ctl.rot_dn, off_r == PW'($past(off_r) - 1'b1), "port offset lost on rotate down")
  `MHTQ_ASSERT_SAME(a_wr_still, ring_ctl.wr_en, !ring_ctl.rot_up && !ring_ctl.rot_dn, "port write while ring moves")
  `MHTQ_ASSERT_NEXT(a_cmd_busy, in_tvalid && in_tready, state_r != S_IDLE, "command accepted without work")

endmodule
